// ===== hdl/rss_pkg.sv =====
// ----------------------------------------------------------------------------
// rss_pkg
// Shared widths, types and state codes of the running sample statistics unit.
// ----------------------------------------------------------------------------
package rss_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int FRAC_BITS   = 16;
	localparam int MAX_COUNT   = 16384;
	localparam int COUNT_W     = 15;
	localparam int SUM_W       = 31;
	localparam int SQSUM_W     = 45;
	localparam int SQ_W        = 2 * SAMPLE_W - 1;
	localparam int MAG_W       = SUM_W - 1;
	localparam int MEAN_W      = 32;
	localparam int VAR_W       = 47;
	localparam int LO_W        = 23;
	localparam int HI_W        = SQSUM_W - LO_W;
	localparam int PL_W        = COUNT_W + LO_W;
	localparam int PH_W        = COUNT_W + HI_W;
	localparam int DIFF_W      = COUNT_W + SQSUM_W;
	localparam int MSQ_W       = 2 * MAG_W;
	localparam int C2_W        = 2 * COUNT_W;
	localparam int NUM_W       = DIFF_W + FRAC_BITS;
	localparam int STEP_W      = $clog2(NUM_W);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [SAMPLE_W-1:0] maximum;
		logic [SAMPLE_W-1:0] minimum;
		logic [COUNT_W-1:0]  count;
		logic [SUM_W-1:0]    sum;
		logic [SQSUM_W-1:0]  sqsum;
		logic                drop;
	} rss_snap_t;

	typedef struct packed {
		logic full;
		logic empty;
	} rss_qstat_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_SUM,
		BK_DIFF,
		BK_DIV,
		BK_DONE
	} rss_bk_state_t;

endpackage

// ===== hdl/running_sample_statistics_unit.sv =====
// ----------------------------------------------------------------------------
// running_sample_statistics_unit
// Running maximum, minimum, count, mean and population variance of signed
// sample runs, one result per run on the beat marked last.
//
//   Channel  Direction  Fields
//   in       sink       sample, last
//   out      source     maximum, minimum, sample_total, mean_fixed,
//                       variance_fixed, overflowed
//
// The front takes one sample beat per cycle; it stalls only when a last beat
// finds the two-entry snapshot queue full.
// Each run's result is worked out after its last beat reaches the back,
// by the one-bit-per-cycle dividers over a 76-bit numerator.
// The back finishes one run before it takes the next snapshot from the queue.
// Reset clears all control state and the running sums; no clearing pass.
// ----------------------------------------------------------------------------
module running_sample_statistics_unit
	import rss_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] maximum,
	output logic signed [SAMPLE_W-1:0] minimum,
	output logic [COUNT_W-1:0]         sample_total,
	output logic signed [MEAN_W-1:0]   mean_fixed,
	output logic [VAR_W-1:0]           variance_fixed,
	output logic                       overflowed
);

	rss_qstat_t qstat;
	rss_snap_t  push_data, pop_data;
	logic       push, pop;

	rss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.last      (last),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	rss_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	rss_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.qstat          (qstat),
		.pop_data       (pop_data),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.maximum        (maximum),
		.minimum        (minimum),
		.sample_total   (sample_total),
		.mean_fixed     (mean_fixed),
		.variance_fixed (variance_fixed),
		.overflowed     (overflowed)
	);

endmodule

// ===== hdl/rss_front.sv =====
// ----------------------------------------------------------------------------
// rss_front
// Accepts samples, squares them and keeps the running extremes, count, sum
// and sum of squares; pushes a snapshot of the run on its last beat.
// ----------------------------------------------------------------------------
module rss_front
	import rss_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       last,
	input  rss_qstat_t                 qstat,
	output logic                       push,
	output rss_snap_t                  push_data
);

	logic                       valid_s1;
	logic                       last_s1;
	logic signed [SAMPLE_W-1:0] x_s1;
	logic [SQ_W-1:0]            sq_s1;
	logic signed [2*SAMPLE_W-1:0] sq_full;

	logic signed [SAMPLE_W-1:0] max_q, min_q, max_n, min_n;
	logic [COUNT_W-1:0]         count_q, count_n;
	logic [SUM_W-1:0]           sum_q, sum_n;
	logic [SQSUM_W-1:0]         sqsum_q, sqsum_n;
	logic                       drop_q, drop_n;
	logic                       adv, full_run, first;

	assign sq_full  = sample * sample;
	assign adv      = valid_s1 && !(last_s1 && qstat.full);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			x_s1    <= sample;
			last_s1 <= last;
			sq_s1   <= sq_full[SQ_W-1:0];
		end
	end

	assign full_run = (count_q == COUNT_W'(MAX_COUNT));
	assign first    = (count_q == '0);

	always_comb begin
		max_n   = max_q;
		min_n   = min_q;
		count_n = count_q;
		sum_n   = sum_q;
		sqsum_n = sqsum_q;
		drop_n  = drop_q;
		if (full_run) begin
			drop_n = 1'b1;
		end else begin
			max_n   = (first || (x_s1 > max_q)) ? x_s1 : max_q;
			min_n   = (first || (x_s1 < min_q)) ? x_s1 : min_q;
			count_n = count_q + COUNT_W'(1);
			sum_n   = sum_q + {{(SUM_W-SAMPLE_W){x_s1[SAMPLE_W-1]}}, x_s1};
			sqsum_n = sqsum_q + SQSUM_W'(sq_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= '0;
			min_q   <= '0;
			count_q <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
			drop_q  <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				max_q   <= '0;
				min_q   <= '0;
				count_q <= '0;
				sum_q   <= '0;
				sqsum_q <= '0;
				drop_q  <= 1'b0;
			end else begin
				max_q   <= max_n;
				min_q   <= min_n;
				count_q <= count_n;
				sum_q   <= sum_n;
				sqsum_q <= sqsum_n;
				drop_q  <= drop_n;
			end
		end
	end

	assign push              = adv && last_s1;
	assign push_data.maximum = max_n;
	assign push_data.minimum = min_n;
	assign push_data.count   = count_n;
	assign push_data.sum     = sum_n;
	assign push_data.sqsum   = sqsum_n;
	assign push_data.drop    = drop_n;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(MAX_COUNT))
		else $error("run count exceeds its limit");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (count_q == '0 && !drop_q))
		else $error("run state not cleared after last beat");

endmodule

// ===== hdl/rss_queue.sv =====
// ----------------------------------------------------------------------------
// rss_queue
// Short queue of finished run snapshots between the front and the back.
// ----------------------------------------------------------------------------
module rss_queue
	import rss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  rss_snap_t  push_data,
	input  logic       pop,
	output rss_snap_t  pop_data,
	output rss_qstat_t qstat
);

	rss_snap_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   fill_q;

	assign qstat.full  = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign qstat.empty = (fill_q == '0);
	assign pop_data    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (QPTR_W+1)'(1);
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full))
		else $error("push into a full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qstat.empty))
		else $error("pop from an empty queue");

endmodule

// ===== hdl/rss_back.sv =====
// ----------------------------------------------------------------------------
// rss_back
// Turns a run snapshot into mean and variance with two bit-serial dividers
// that step together, and holds the result in the output register.
// ----------------------------------------------------------------------------
module rss_back
	import rss_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  rss_qstat_t                 qstat,
	input  rss_snap_t                  pop_data,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] maximum,
	output logic signed [SAMPLE_W-1:0] minimum,
	output logic [COUNT_W-1:0]         sample_total,
	output logic signed [MEAN_W-1:0]   mean_fixed,
	output logic [VAR_W-1:0]           variance_fixed,
	output logic                       overflowed
);

	rss_bk_state_t state_q, state_n;
	logic          load_out;

	logic [SAMPLE_W-1:0] max_q, min_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [SQSUM_W-1:0]  sqs_q;
	logic [MAG_W-1:0]    mag_q;
	logic                neg_q, drop_q;
	logic [PL_W-1:0]     pl_q;
	logic [PH_W-1:0]     ph_q;
	logic [MSQ_W-1:0]    msq_q;
	logic [C2_W-1:0]     c2_q;
	logic [DIFF_W-1:0]   prod_q;
	logic [NUM_W-1:0]    mnum_q, vnum_q;
	logic [COUNT_W-1:0]  mrem_q, mrem_n;
	logic [C2_W-1:0]     vrem_q, vrem_n;
	logic [MEAN_W-1:0]   mquo_q;
	logic [VAR_W-1:0]    vquo_q;
	logic [STEP_W-1:0]   step_q;
	logic [COUNT_W:0]    mtrial;
	logic [C2_W:0]       vtrial;
	logic                mge, vge;
	logic [SUM_W-1:0]    sum_abs;

	logic signed [SAMPLE_W-1:0] omax_q, omin_q;
	logic [COUNT_W-1:0]         ocnt_q;
	logic signed [MEAN_W-1:0]   omean_q;
	logic [VAR_W-1:0]           ovar_q;
	logic                       odrop_q;
	logic                       ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!qstat.empty) begin
					pop     = 1'b1;
					state_n = BK_MUL;
				end
			end
			BK_MUL:  state_n = BK_SUM;
			BK_SUM:  state_n = BK_DIFF;
			BK_DIFF: state_n = BK_DIV;
			BK_DIV: begin
				if (step_q == STEP_W'(NUM_W - 1)) begin
					state_n = BK_DONE;
				end
			end
			BK_DONE: begin
				if (!ovalid_q || out_ready) begin
					load_out = 1'b1;
					state_n  = BK_IDLE;
				end
			end
			default: state_n = BK_IDLE;
		endcase
	end

	assign sum_abs = pop_data.sum[SUM_W-1] ? (~pop_data.sum + SUM_W'(1)) : pop_data.sum;

	assign mtrial = {mrem_q, mnum_q[NUM_W-1]};
	assign mge    = (mtrial >= {1'b0, cnt_q});
	assign mrem_n = mge ? COUNT_W'(mtrial - {1'b0, cnt_q}) : mtrial[COUNT_W-1:0];
	assign vtrial = {vrem_q, vnum_q[NUM_W-1]};
	assign vge    = (vtrial >= {1'b0, c2_q});
	assign vrem_n = vge ? C2_W'(vtrial - {1'b0, c2_q}) : vtrial[C2_W-1:0];

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				max_q  <= pop_data.maximum;
				min_q  <= pop_data.minimum;
				cnt_q  <= pop_data.count;
				sqs_q  <= pop_data.sqsum;
				drop_q <= pop_data.drop;
				neg_q  <= pop_data.sum[SUM_W-1];
				mag_q  <= sum_abs[MAG_W-1:0];
			end
			BK_MUL: begin
				pl_q  <= PL_W'(cnt_q) * PL_W'(sqs_q[LO_W-1:0]);
				ph_q  <= PH_W'(cnt_q) * PH_W'(sqs_q[SQSUM_W-1:LO_W]);
				msq_q <= MSQ_W'(mag_q) * MSQ_W'(mag_q);
				c2_q  <= C2_W'(cnt_q) * C2_W'(cnt_q);
			end
			BK_SUM: begin
				prod_q <= (DIFF_W'(ph_q) << LO_W) + DIFF_W'(pl_q);
			end
			BK_DIFF: begin
				vnum_q <= NUM_W'(prod_q - DIFF_W'(msq_q)) << FRAC_BITS;
				mnum_q <= NUM_W'(mag_q) << FRAC_BITS;
				mrem_q <= '0;
				vrem_q <= '0;
				step_q <= '0;
			end
			BK_DIV: begin
				mnum_q <= mnum_q << 1;
				vnum_q <= vnum_q << 1;
				mrem_q <= mrem_n;
				vrem_q <= vrem_n;
				mquo_q <= {mquo_q[MEAN_W-2:0], mge};
				vquo_q <= {vquo_q[VAR_W-2:0], vge};
				step_q <= step_q + STEP_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			omax_q  <= max_q;
			omin_q  <= min_q;
			ocnt_q  <= cnt_q;
			omean_q <= neg_q ? (~mquo_q + MEAN_W'(1)) : mquo_q;
			ovar_q  <= vquo_q;
			odrop_q <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (load_out) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	assign out_valid      = ovalid_q;
	assign maximum        = omax_q;
	assign minimum        = omin_q;
	assign sample_total   = ocnt_q;
	assign mean_fixed     = omean_q;
	assign variance_fixed = ovar_q;
	assign overflowed     = odrop_q;

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (state_q == BK_DONE))
		else $error("result loaded outside the final state");

	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == BK_MUL))
		else $error("snapshot taken without starting the arithmetic");

endmodule
